// ----- rtl/core/slac_pkg.sv -----
package slac_pkg;

  localparam int unsigned IN_DATA_W  = 192;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UD = 2'd1;
  localparam logic [1:0] ST_GP = 2'd2;
  localparam logic [1:0] ST_SS = 2'd3;

  localparam logic [2:0] SEG_SS       = 3'd2;
  localparam logic [2:0] SEG_FS       = 3'd4;
  localparam logic [2:0] SEG_LAST     = 3'd5;

  localparam int unsigned RB_WRITABLE = 1;
  localparam int unsigned RB_EXPDOWN  = 2;
  localparam int unsigned RB_CODE     = 3;
  localparam int unsigned RB_UNUSABLE = 16;

  localparam logic [31:0] LOW32 = 32'hffff_ffff;

  typedef struct packed {
    logic [2:0]  segment_index;
    logic [63:0] offset;
    logic        is_write;
    logic [2:0]  access_bytes;
    logic [63:0] seg_base;
    logic [31:0] seg_limit;
    logic [16:0] seg_rights;
    logic        real_mode;
    logic        long_mode;
    logic        five_level;
  } req_t;

  // after address generation
  typedef struct packed {
    logic [63:0] lin;
    logic        ud;
    logic        long_mode;
    logic        five_level;
    logic        seg_ss;
    logic        rights_gp;
    logic        unusable;
    logic        nonflat;
    logic [31:0] limit;
    logic [2:0]  size;
  } gen_t;

  // after canonical check and limit operand preparation
  typedef struct packed {
    logic [63:0] lin;
    logic        ud;
    logic        long_mode;
    logic        canon_ok;
    logic        seg_ss;
    logic        rights_gp;
    logic        unusable;
    logic        nonflat;
    logic [32:0] end_plus1;
    logic [32:0] limit_plus1;
  } chk_t;

  typedef struct packed {
    logic [63:0] linear_address;
    logic [1:0]  status;
  } res_t;

endpackage

// ----- rtl/core/slac_gen.sv -----
module slac_gen (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  slac_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_ready,
  output slac_pkg::gen_t out_gen
);

  logic            valid;
  slac_pkg::gen_t  gen;
  slac_pkg::gen_t  gen_next;
  logic [63:0]     eff_base;
  logic            seg_high;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_gen   = gen;

  always_comb begin
    seg_high = in_req.segment_index >= slac_pkg::SEG_FS;
    // long mode: only fs and gs carry a base
    eff_base = (in_req.long_mode && !seg_high) ? 64'd0 : in_req.seg_base;

    gen_next.lin        = eff_base + in_req.offset;
    gen_next.ud         = in_req.real_mode || (in_req.segment_index > slac_pkg::SEG_LAST);
    gen_next.long_mode  = in_req.long_mode;
    gen_next.five_level = in_req.five_level;
    gen_next.seg_ss     = in_req.segment_index == slac_pkg::SEG_SS;
    if (in_req.is_write) begin
      gen_next.rights_gp = (!in_req.seg_rights[slac_pkg::RB_WRITABLE] &&
                            !in_req.seg_rights[slac_pkg::RB_CODE]) ||
                           in_req.seg_rights[slac_pkg::RB_CODE];
    end else begin
      // execute-only code segment
      gen_next.rights_gp = in_req.seg_rights[slac_pkg::RB_CODE] &&
                           !in_req.seg_rights[slac_pkg::RB_WRITABLE];
    end
    gen_next.unusable = in_req.seg_rights[slac_pkg::RB_UNUSABLE];
    gen_next.nonflat  = (in_req.seg_base != 64'd0) || (in_req.seg_limit != slac_pkg::LOW32) ||
                        (!in_req.seg_rights[slac_pkg::RB_CODE] &&
                         in_req.seg_rights[slac_pkg::RB_EXPDOWN]);
    gen_next.limit    = in_req.seg_limit;
    gen_next.size     = in_req.access_bytes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      gen <= gen_next;
    end
  end

endmodule

// ----- rtl/core/slac_check.sv -----
module slac_check (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  slac_pkg::gen_t in_gen,
  output logic           out_valid,
  input  logic           out_ready,
  output slac_pkg::chk_t out_chk
);

  logic            valid;
  slac_pkg::chk_t  chk;
  slac_pkg::chk_t  chk_next;
  logic [16:0]     top48;
  logic [7:0]      top57;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_chk   = chk;

  always_comb begin
    top48 = in_gen.lin[63:47];
    top57 = in_gen.lin[63:56];

    chk_next.lin       = in_gen.lin;
    chk_next.ud        = in_gen.ud;
    chk_next.long_mode = in_gen.long_mode;
    chk_next.canon_ok  = in_gen.five_level ? ((&top57) || !(|top57))
                                           : ((&top48) || !(|top48));
    chk_next.seg_ss    = in_gen.seg_ss;
    chk_next.rights_gp = in_gen.rights_gp;
    chk_next.unusable  = in_gen.unusable;
    chk_next.nonflat   = in_gen.nonflat;
    // end + 1 against limit + 1 avoids the minus one, zero end wraps and faults
    chk_next.end_plus1   = {1'b0, in_gen.lin[31:0]} + {30'd0, in_gen.size};
    chk_next.limit_plus1 = {1'b0, in_gen.limit} + 33'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      chk <= chk_next;
    end
  end

endmodule

// ----- rtl/core/slac_resolve.sv -----
module slac_resolve (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  slac_pkg::chk_t in_chk,
  output logic           out_valid,
  input  logic           out_ready,
  output slac_pkg::res_t out_res
);

  logic            valid;
  slac_pkg::res_t  res;
  slac_pkg::res_t  res_next;
  logic            limit_ok;
  logic [1:0]      fault_code;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_res   = res;

  always_comb begin
    limit_ok   = (in_chk.end_plus1 != 33'd0) && (in_chk.end_plus1 <= in_chk.limit_plus1);
    fault_code = in_chk.seg_ss ? slac_pkg::ST_SS : slac_pkg::ST_GP;
    if (in_chk.ud) begin
      res_next.linear_address = 64'd0;
      res_next.status         = slac_pkg::ST_UD;
    end else if (in_chk.long_mode) begin
      res_next.linear_address = in_chk.lin;
      res_next.status         = in_chk.canon_ok ? slac_pkg::ST_OK : fault_code;
    end else begin
      res_next.linear_address = {32'd0, in_chk.lin[31:0]};
      // rights faults are general protection even through ss
      if (in_chk.rights_gp) begin
        res_next.status = slac_pkg::ST_GP;
      end else if (in_chk.unusable || (in_chk.nonflat && !limit_ok)) begin
        res_next.status = fault_code;
      end else begin
        res_next.status = slac_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res <= res_next;
    end
  end

endmodule

// ----- rtl/core/segment_linear_address_check.sv -----
// an accepted request passes through three register stages to its result on the master side
// throughput: one request per cycle while m_tready does not stall the stages
// (stages: address add, canonical and limit preparation, status resolve)
// a stalled stage holds its request; ready ripples back through the stages
// reset (synchronous, active high) clears the stage valid bits only
module segment_linear_address_check (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // segment_index[2:0], offset[66:3], is_write[67], access_bytes[70:68],
  // seg_base[134:71], seg_limit[166:135], seg_rights[183:167],
  // real_mode[184], long_mode[185], five_level[186], zero fill
  input  logic [slac_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // linear_address[63:0], status[65:64], zero fill
  output logic [slac_pkg::OUT_DATA_W-1:0]   m_tdata
);

  slac_pkg::req_t req;
  slac_pkg::gen_t gen;
  slac_pkg::chk_t chk;
  slac_pkg::res_t res;
  logic           gen_valid;
  logic           gen_ready;
  logic           chk_valid;
  logic           chk_ready;

  always_comb begin
    req.segment_index = s_tdata[2:0];
    req.offset        = s_tdata[66:3];
    req.is_write      = s_tdata[67];
    req.access_bytes  = s_tdata[70:68];
    req.seg_base      = s_tdata[134:71];
    req.seg_limit     = s_tdata[166:135];
    req.seg_rights    = s_tdata[183:167];
    req.real_mode     = s_tdata[184];
    req.long_mode     = s_tdata[185];
    req.five_level    = s_tdata[186];
  end

  slac_gen u_gen (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (req),
    .out_valid (gen_valid),
    .out_ready (gen_ready),
    .out_gen   (gen)
  );

  slac_check u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (gen_valid),
    .in_ready  (gen_ready),
    .in_gen    (gen),
    .out_valid (chk_valid),
    .out_ready (chk_ready),
    .out_chk   (chk)
  );

  slac_resolve u_resolve (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chk_valid),
    .in_ready  (chk_ready),
    .in_chk    (chk),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {6'd0, res.status, res.linear_address};

endmodule
